[rtl/core/tld_pkg.sv]
package tld_pkg;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 12;

	localparam logic [CFG_INDEX_W-1:0] REG_ABS_MARGIN    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RATIO_DIVISOR = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RUN_LENGTH    = 2'd2;

	// Register widths and reset values
	localparam int MARGIN_W = 12;
	localparam int RATIO_W  = 8;
	localparam int RUN_W    = 4;

	localparam logic [MARGIN_W-1:0] ABS_MARGIN_RST    = 12'd20;
	localparam logic [RATIO_W-1:0]  RATIO_DIVISOR_RST = 8'd10;
	localparam logic [RUN_W-1:0]    RUN_LENGTH_RST    = 4'd3;

	// Anomaly history and result width
	localparam int HIST_W = 8;
	localparam int MEAN_OUT_W = 12;

	// Status of the item held in the decision stage
	typedef struct packed {
		logic valid;
		logic calib;
	} stage_t;

	// Decision stage events fed back to the window front end
	typedef struct packed {
		logic take;
		logic tamper;
	} flow_t;

	// Mask of the last run_length history bits; zero counts as one, above eight as eight
	function automatic logic [HIST_W-1:0] run_mask(input logic [RUN_W-1:0] len);
		logic [RUN_W-1:0] eff;
		logic [HIST_W-1:0] mask;
		if (len == '0) begin
			eff = RUN_W'(1);
		end else if (len > RUN_W'(HIST_W)) begin
			eff = RUN_W'(HIST_W);
		end else begin
			eff = len;
		end
		for (int i = 0; i < HIST_W; i++) begin
			mask[i] = (RUN_W'(i) < eff);
		end
		return mask;
	endfunction

endpackage

[rtl/core/tld_ring.sv]
module tld_ring #(
	parameter int DEPTH  = 10,
	parameter int DATA_W = 12
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/tld_window.sv]
module tld_window #(
	parameter int WINDOW_SIZE = 10,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  tld_pkg::flow_t         flow,
	output tld_pkg::stage_t        stage_s2,
	output logic [SAMPLE_BITS-1:0] sample_s2,
	output logic [SAMPLE_BITS-1:0] mean_s2
);
	import tld_pkg::*;

	localparam int IDX_W   = $clog2(WINDOW_SIZE);
	localparam int FILL_W  = $clog2(WINDOW_SIZE + 1);
	localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_SIZE);
	// Exact reciprocal for division of a SUM_W-bit value by the window size
	localparam int SHIFT   = SUM_W + $clog2(WINDOW_SIZE);
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW_SIZE)
		- 64'd1) / 64'(WINDOW_SIZE));

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   valid_s2;
	logic                   calib_s2;

	logic [IDX_W-1:0]  slot_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  sum_q;

	logic                   s2_free;
	logic                   adv1;
	logic                   accept;
	logic                   calib1;
	logic [SAMPLE_BITS-1:0] old_data;
	logic [SAMPLE_BITS-1:0] old_eff;
	logic [PROD_W-1:0]      mean_prod;
	logic [SAMPLE_BITS-1:0] mean1;
	logic [SUM_W-1:0]       sum_n;
	logic [IDX_W-1:0]       slot_n;
	logic [FILL_W-1:0]      fill_n;
	logic [IDX_W-1:0]       wr_addr;
	logic [IDX_W-1:0]       rd_addr;

	// Handshake: s1 may move when s2 is empty or leaving
	assign s2_free  = !valid_s2 || flow.take;
	assign adv1     = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;
	assign accept   = in_valid && in_ready;

	// Window not yet full: only store, oldest entry counts as empty
	assign calib1  = (fill_q < FILL_W'(WINDOW_SIZE));
	assign old_eff = calib1 ? '0 : old_data;

	// Mean of the window before the sample in s1
	assign mean_prod = PROD_W'(sum_q) * PROD_W'(RECIP);
	assign mean1     = mean_prod[SHIFT +: SAMPLE_BITS];

	// Next window state; a tamper empties it and keeps only the item now moving to s2
	always_comb begin
		sum_n  = sum_q;
		slot_n = slot_q;
		fill_n = fill_q;
		if (flow.tamper) begin
			sum_n  = adv1 ? SUM_W'(sample_s1) : '0;
			slot_n = adv1 ? IDX_W'(1) : '0;
			fill_n = adv1 ? FILL_W'(1) : '0;
		end else if (adv1) begin
			sum_n  = sum_q - SUM_W'(old_eff) + SUM_W'(sample_s1);
			slot_n = (slot_q == IDX_W'(WINDOW_SIZE - 1)) ? '0 : slot_q + IDX_W'(1);
			fill_n = calib1 ? fill_q + FILL_W'(1) : fill_q;
		end
	end

	// Memory addresses: store at the current slot, fetch the oldest for the new item
	assign wr_addr = flow.tamper ? '0 : slot_q;
	assign rd_addr = slot_n;

	tld_ring #(
		.DEPTH  (WINDOW_SIZE),
		.DATA_W (SAMPLE_BITS)
	) u_ring (
		.clk     (clk),
		.wr_en   (adv1),
		.wr_addr (wr_addr),
		.wr_data (sample_s1),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (old_data)
	);

	// Window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else begin
			slot_q <= slot_n;
			fill_q <= fill_n;
			sum_q  <= sum_n;
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (flow.take) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
		if (adv1) begin
			sample_s2 <= sample_s1;
			mean_s2   <= mean1;
			calib_s2  <= calib1 || flow.tamper;
		end
	end

	assign stage_s2.valid = valid_s2;
	assign stage_s2.calib = calib_s2;

endmodule

[rtl/core/tld_judge.sv]
module tld_judge #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tld_pkg::stage_t                      stage_s2,
	input  logic [SAMPLE_BITS-1:0]               sample_s2,
	input  logic [SAMPLE_BITS-1:0]               mean_s2,
	input  logic [tld_pkg::MARGIN_W-1:0]         abs_margin,
	input  logic [tld_pkg::RATIO_W-1:0]          ratio_divisor,
	input  logic [tld_pkg::RUN_W-1:0]            run_length,
	output tld_pkg::flow_t                       flow,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [tld_pkg::MEAN_OUT_W-1:0]       window_mean,
	output logic                                 calibrating,
	output logic                                 anomaly,
	output logic                                 tamper
);
	import tld_pkg::*;

	localparam int CMP_W  = (SAMPLE_BITS > MARGIN_W) ? SAMPLE_BITS : MARGIN_W;
	localparam int DPROD_W = SAMPLE_BITS + RATIO_W;

	logic                    out_valid_q;
	logic [MEAN_OUT_W-1:0]   window_mean_q;
	logic                    calibrating_q;
	logic                    anomaly_q;
	logic                    tamper_q;
	logic [HIST_W-1:0]       hist_q;

	logic                    take;
	logic [SAMPLE_BITS-1:0]  dev;
	logic [DPROD_W-1:0]      dev_prod;
	logic                    big_dev;
	logic                    anom;
	logic [HIST_W-1:0]       hist_or;
	logic [HIST_W-1:0]       need;
	logic                    tamp;
	logic [HIST_W-1:0]       hist_n;
	logic [CMP_W-1:0]        mean_ext;

	// Move the decided item into the output register when it is free
	assign take = stage_s2.valid && (!out_valid_q || out_ready);

	// Deviation tests against the absolute margin and the scaled mean
	assign dev      = (sample_s2 > mean_s2) ? sample_s2 - mean_s2 : mean_s2 - sample_s2;
	assign dev_prod = DPROD_W'(dev) * DPROD_W'(ratio_divisor);
	assign big_dev  = CMP_W'(dev) > CMP_W'(abs_margin);
	assign anom     = !stage_s2.calib && big_dev && (dev_prod > DPROD_W'(mean_s2));

	// Anomaly run check
	assign hist_or = hist_q | HIST_W'(anom);
	assign need    = run_mask(run_length);
	assign tamp    = !stage_s2.calib && ((hist_or & need) == need);
	assign hist_n  = tamp ? '0 : {hist_or[HIST_W-2:0], 1'b0};

	assign mean_ext = CMP_W'(mean_s2);

	// History and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				hist_q      <= hist_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (take) begin
			window_mean_q <= stage_s2.calib ? '0 : mean_ext[MEAN_OUT_W-1:0];
			calibrating_q <= stage_s2.calib;
			anomaly_q     <= anom;
			tamper_q      <= tamp;
		end
	end

	assign flow.take   = take;
	assign flow.tamper = take && tamp;

	assign out_valid   = out_valid_q;
	assign window_mean = window_mean_q;
	assign calibrating = calibrating_q;
	assign anomaly     = anomaly_q;
	assign tamper      = tamper_q;

endmodule

[rtl/core/light_tamper_detector.sv]
// Light tamper detector: moving-average deviation check on a light sensor stream.
// Input channel in_valid/in_ready carries one sample per transaction; the output
// channel out_valid/out_ready returns one result per sample, in order: window mean,
// calibrating, anomaly and tamper flags.
// The configuration channel cfg_valid/cfg_ready writes abs_margin (index 0),
// ratio_divisor (1) and run_length (2); other indexes are dropped. cfg_ready is
// always high; write only while no sample is in flight.
// A result passes through stage s1, stage s2 and the result register. Throughput:
// one sample per cycle while the receiver takes results, set by the ring memory taking
// one write and one read per cycle and the window sum being updated once per sample.
// Reset clears the window, the anomaly history and loads the register defaults
// (20, 10, 3). The first WINDOW_SIZE samples after reset or after a tamper only
// fill the window and come back flagged as calibrating. The ring memory needs no
// clearing pass.
// When the receiver stalls, the result register holds and the two internal stages
// keep filling; in_ready drops only once both stages and the result register are full.
module light_tamper_detector #(
	parameter int WINDOW_SIZE = 10,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [SAMPLE_BITS-1:0]            sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tld_pkg::MEAN_OUT_W-1:0]    window_mean,
	output logic                              calibrating,
	output logic                              anomaly,
	output logic                              tamper,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tld_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tld_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tld_pkg::*;

	logic [MARGIN_W-1:0]    abs_margin_q;
	logic [RATIO_W-1:0]     ratio_divisor_q;
	logic [RUN_W-1:0]       run_length_q;

	stage_t                 stage_s2;
	flow_t                  flow;
	logic [SAMPLE_BITS-1:0] sample_s2;
	logic [SAMPLE_BITS-1:0] mean_s2;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_margin_q    <= ABS_MARGIN_RST;
			ratio_divisor_q <= RATIO_DIVISOR_RST;
			run_length_q    <= RUN_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ABS_MARGIN: begin
					abs_margin_q <= cfg_data[MARGIN_W-1:0];
				end
				REG_RATIO_DIVISOR: begin
					ratio_divisor_q <= cfg_data[RATIO_W-1:0];
				end
				REG_RUN_LENGTH: begin
					run_length_q <= cfg_data[RUN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	tld_window #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.flow      (flow),
		.stage_s2  (stage_s2),
		.sample_s2 (sample_s2),
		.mean_s2   (mean_s2)
	);

	tld_judge #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_judge (
		.clk           (clk),
		.arst_n        (arst_n),
		.stage_s2      (stage_s2),
		.sample_s2     (sample_s2),
		.mean_s2       (mean_s2),
		.abs_margin    (abs_margin_q),
		.ratio_divisor (ratio_divisor_q),
		.run_length    (run_length_q),
		.flow          (flow),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.window_mean   (window_mean),
		.calibrating   (calibrating),
		.anomaly       (anomaly),
		.tamper        (tamper)
	);

endmodule
